[rtl/core/bba_pkg.sv]
// Package: constants, item types and controller/datapath interface structs.
`timescale 1ns / 1ps
package bba_pkg;

   localparam int PAGE_COUNT   = 8;
   localparam int PAGE_LOG     = 12;
   localparam int HEADER_BYTES = 16;
   localparam int MIN_LOG      = 4;

   localparam int GRAN_LOG    = PAGE_LOG - MIN_LOG;
   localparam int PAGE_BITS   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int IDX_BITS    = PAGE_BITS + GRAN_LOG;
   localparam int TABLE_DEPTH = PAGE_COUNT << GRAN_LOG;
   localparam int POOL_BYTES  = PAGE_COUNT << PAGE_LOG;
   localparam int EXP_BITS    = $clog2(PAGE_LOG + 2);
   localparam int CNT_BITS    = $clog2(PAGE_COUNT + 1);

   localparam int REQ_BITS  = 14;
   localparam int ADDR_BITS = 15;
   localparam int NEED_BITS = REQ_BITS + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_NO_PAGE   = 2'd2;

   typedef struct packed {
      logic                 opcode;
      logic [REQ_BITS-1:0]  request_bytes;
      logic [ADDR_BITS-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] block_address;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic                head;
      logic                used;
      logic [EXP_BITS-1:0] exp;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       scan_step;
      logic       open_init;
      logic       open_step;
      logic       split_step;
      logic       commit;
      logic       free_rd;
      logic       free_mark;
      logic       merge_rd;
      logic       merge_whi;
      logic       merge_wlo;
      logic       respond;
      logic       rsp_grant;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic too_large;
      logic addr_ok;
      logic scan_done;
      logic found;
      logic pool_full;
      logic clr_last;
      logic split_done;
      logic at_top;
      logic head_used;
      logic merge_ok;
   } sts_type;

endpackage

[rtl/core/bba_dp.sv]
// Datapath: block table memory, scan/split/merge registers and result register.
`timescale 1ns / 1ps
module bba_dp import bba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_item,
   input  logic    csr_we,
   input  logic    csr_wdata,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   entry_type table_mem [TABLE_DEPTH];

   logic                 fit_mode_ff;
   logic                 op_ff;
   logic [EXP_BITS-1:0]  fit_ff;
   logic                 too_large_ff;
   logic [ADDR_BITS-1:0] free_addr_ff;
   logic [CNT_BITS-1:0]  pages_ff;
   logic                 iss_active_ff;
   logic [PAGE_BITS-1:0] iss_page_ff;
   logic [GRAN_LOG-1:0]  iss_gran_ff;
   logic                 rd_valid_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [EXP_BITS-1:0]  pick_exp_ff;
   logic [IDX_BITS-1:0]  bud_ff;
   logic [GRAN_LOG-1:0]  clr_gran_ff;
   entry_type            rdata_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_item_ff;

   logic [NEED_BITS-1:0] need;
   logic [EXP_BITS-1:0]  fit_in;
   logic                 too_large_in;
   logic [ADDR_BITS-1:0] free_off;
   logic                 addr_ok;
   logic [IDX_BITS-1:0]  free_idx;
   logic                 cand;
   logic                 take;
   logic [IDX_BITS-1:0]  split_bud;
   logic [IDX_BITS-1:0]  merge_bud;
   logic [IDX_BITS-1:0]  lo_idx;
   logic [IDX_BITS-1:0]  hi_idx;
   logic [ADDR_BITS:0]   grant_sum;
   logic                 we;
   logic [IDX_BITS-1:0]  waddr;
   entry_type            wdata;
   logic [IDX_BITS-1:0]  raddr;

   always_comb begin
      need = ((req_item.request_bytes == '0) ? NEED_BITS'(1)
              : NEED_BITS'(req_item.request_bytes)) + NEED_BITS'(HEADER_BYTES);
      fit_in = EXP_BITS'(PAGE_LOG);
      for (int e = PAGE_LOG; e >= MIN_LOG; e--) begin
         if (32'(need) <= (32'd1 << e)) fit_in = EXP_BITS'(e);
      end
      too_large_in = 32'(need) > (32'd1 << PAGE_LOG);
   end

   assign free_off = free_addr_ff - ADDR_BITS'(HEADER_BYTES);
   assign addr_ok  = (32'(free_addr_ff) >= HEADER_BYTES) && (32'(free_off) < POOL_BYTES)
                     && (free_off[MIN_LOG-1:0] == '0)
                     && ((32'(free_off) >> PAGE_LOG) < 32'(pages_ff));
   assign free_idx = free_off[MIN_LOG +: IDX_BITS];

   assign cand = rdata_ff.head && !rdata_ff.used && (rdata_ff.exp >= fit_ff);
   assign take = rd_valid_ff && cand
                 && (!found_ff || (!fit_mode_ff && (rdata_ff.exp < pick_exp_ff)));

   assign split_bud = pick_ff + (IDX_BITS'(1) << (pick_exp_ff - EXP_BITS'(MIN_LOG + 1)));
   assign merge_bud = pick_ff ^ (IDX_BITS'(1) << (pick_exp_ff - EXP_BITS'(MIN_LOG)));
   assign lo_idx    = (bud_ff < pick_ff) ? bud_ff : pick_ff;
   assign hi_idx    = (bud_ff < pick_ff) ? pick_ff : bud_ff;
   assign grant_sum = (ADDR_BITS + 1)'({pick_ff, {MIN_LOG{1'b0}}}) + (ADDR_BITS + 1)'(HEADER_BYTES);

   always_comb begin
      we    = 1'b0;
      waddr = pick_ff;
      wdata = '0;
      priority if (cmd.open_step) begin
         we    = 1'b1;
         waddr = {pick_ff[IDX_BITS-1:GRAN_LOG], clr_gran_ff};
         if (clr_gran_ff == '0) wdata = '{1'b1, 1'b0, EXP_BITS'(PAGE_LOG)};
      end else if (cmd.split_step) begin
         we    = 1'b1;
         waddr = split_bud;
         wdata = '{1'b1, 1'b0, pick_exp_ff - EXP_BITS'(1)};
      end else if (cmd.commit) begin
         we    = 1'b1;
         wdata = '{1'b1, 1'b1, fit_ff};
      end else if (cmd.free_mark) begin
         we    = 1'b1;
         wdata = '{1'b1, 1'b0, rdata_ff.exp};
      end else if (cmd.merge_whi) begin
         we    = 1'b1;
         waddr = hi_idx;
      end else if (cmd.merge_wlo) begin
         we    = 1'b1;
         waddr = lo_idx;
         wdata = '{1'b1, 1'b0, pick_exp_ff + EXP_BITS'(1)};
      end else begin
         we = 1'b0;
      end
   end

   always_comb begin
      priority if (cmd.free_rd) raddr = free_idx;
      else if (cmd.merge_rd)   raddr = merge_bud;
      else                     raddr = {iss_page_ff, iss_gran_ff};
   end

   always_ff @(posedge clock) begin
      if (we) table_mem[waddr] <= wdata;
      rdata_ff <= table_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= 1'b0;
         pages_ff      <= '0;
         iss_active_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) fit_mode_ff <= csr_wdata;
         rsp_valid_ff <= cmd.respond;
         if (cmd.scan_init) begin
            iss_active_ff <= (pages_ff != '0);
            rd_valid_ff   <= 1'b0;
            found_ff      <= 1'b0;
         end
         if (cmd.scan_step) begin
            rd_valid_ff <= iss_active_ff;
            if (iss_gran_ff == '1 && iss_page_ff == '0) iss_active_ff <= 1'b0;
            if (take) found_ff <= 1'b1;
         end
         if (cmd.open_init) pages_ff <= pages_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_item.opcode;
         fit_ff       <= fit_in;
         too_large_ff <= too_large_in;
         free_addr_ff <= req_item.free_address;
      end
      if (cmd.scan_init) begin
         iss_page_ff <= PAGE_BITS'(pages_ff - CNT_BITS'(1));
         iss_gran_ff <= '0;
      end
      if (cmd.scan_step) begin
         rd_idx_ff   <= {iss_page_ff, iss_gran_ff};
         iss_gran_ff <= iss_gran_ff + GRAN_LOG'(1);
         if (iss_gran_ff == '1) iss_page_ff <= iss_page_ff - PAGE_BITS'(1);
         if (take) begin
            pick_ff     <= rd_idx_ff;
            pick_exp_ff <= rdata_ff.exp;
         end
      end
      if (cmd.open_init) begin
         pick_ff     <= {pages_ff[PAGE_BITS-1:0], {GRAN_LOG{1'b0}}};
         pick_exp_ff <= EXP_BITS'(PAGE_LOG);
         clr_gran_ff <= '0;
      end
      if (cmd.open_step)  clr_gran_ff <= clr_gran_ff + GRAN_LOG'(1);
      if (cmd.split_step) pick_exp_ff <= pick_exp_ff - EXP_BITS'(1);
      if (cmd.free_rd)    pick_ff     <= free_idx;
      if (cmd.free_mark)  pick_exp_ff <= rdata_ff.exp;
      if (cmd.merge_rd)   bud_ff      <= merge_bud;
      if (cmd.merge_wlo) begin
         pick_ff     <= lo_idx;
         pick_exp_ff <= pick_exp_ff + EXP_BITS'(1);
      end
      if (cmd.respond) begin
         rsp_item_ff.status        <= cmd.rsp_status;
         rsp_item_ff.block_address <= cmd.rsp_grant ? grant_sum[ADDR_BITS-1:0] : '0;
      end
   end

   always_comb begin
      sts.is_free    = (op_ff == OP_FREE);
      sts.too_large  = too_large_ff;
      sts.addr_ok    = addr_ok;
      sts.scan_done  = (found_ff && (fit_mode_ff || (pick_exp_ff == fit_ff)))
                       || (!iss_active_ff && !rd_valid_ff);
      sts.found      = found_ff;
      sts.pool_full  = (32'(pages_ff) >= PAGE_COUNT);
      sts.clr_last   = (clr_gran_ff == '1);
      sts.split_done = (pick_exp_ff == fit_ff);
      sts.at_top     = (pick_exp_ff == EXP_BITS'(PAGE_LOG));
      sts.head_used  = rdata_ff.head && rdata_ff.used;
      sts.merge_ok   = rdata_ff.head && !rdata_ff.used && (rdata_ff.exp == pick_exp_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pages_ff) <= PAGE_COUNT) else $error("page count beyond pool");
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status != STATUS_DONE) |-> rsp_item_ff.block_address == '0)
      else $error("error item carries an address");
   a_split_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.split_step |=> pick_exp_ff == $past(pick_exp_ff) - EXP_BITS'(1))
      else $error("split did not halve block");

endmodule

[rtl/core/bba_ctrl.sv]
// Controller: sequences scan, page open, split, free and merge steps.
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_START     = 4'd1;
   localparam logic [3:0] ST_SCAN      = 4'd2;
   localparam logic [3:0] ST_PICK      = 4'd3;
   localparam logic [3:0] ST_OPEN      = 4'd4;
   localparam logic [3:0] ST_SPLIT     = 4'd5;
   localparam logic [3:0] ST_FREE_CHK  = 4'd6;
   localparam logic [3:0] ST_MERGE_RD  = 4'd7;
   localparam logic [3:0] ST_MERGE_CHK = 4'd8;
   localparam logic [3:0] ST_MERGE_WLO = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.is_free) begin
               if (sts.addr_ok) begin
                  cmd.free_rd = 1'b1;
                  state_in    = ST_FREE_CHK;
               end else begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (sts.too_large) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_TOO_LARGE;
               state_in       = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_PICK;
            else cmd.scan_step = 1'b1;
         end
         ST_PICK: begin
            if (sts.found) begin
               state_in = ST_SPLIT;
            end else if (sts.pool_full) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_NO_PAGE;
               state_in       = ST_IDLE;
            end else begin
               cmd.open_init = 1'b1;
               state_in      = ST_OPEN;
            end
         end
         ST_OPEN: begin
            cmd.open_step = 1'b1;
            if (sts.clr_last) state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (sts.split_done) begin
               cmd.commit    = 1'b1;
               cmd.respond   = 1'b1;
               cmd.rsp_grant = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.split_step = 1'b1;
            end
         end
         ST_FREE_CHK: begin
            if (sts.head_used) begin
               cmd.free_mark = 1'b1;
               state_in      = ST_MERGE_RD;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_MERGE_RD: begin
            if (sts.at_top) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.merge_rd = 1'b1;
               state_in     = ST_MERGE_CHK;
            end
         end
         ST_MERGE_CHK: begin
            if (sts.merge_ok) begin
               cmd.merge_whi = 1'b1;
               state_in      = ST_MERGE_WLO;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_MERGE_WLO: begin
            cmd.merge_wlo = 1'b1;
            state_in      = ST_MERGE_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> state_ff == ST_IDLE) else $error("no return to idle after item");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_START) else $error("accepted item not loaded");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.open_step, cmd.split_step, cmd.commit, cmd.free_mark,
                  cmd.merge_whi, cmd.merge_wlo}) <= 1) else $error("table write conflict");

endmodule

[rtl/core/buddy_block_allocator_core.sv]
// Top level: buddy block allocator, controller plus datapath.
//
//  channel  ports                          handshake
//  request  start, busy, req_item          taken when start & !busy
//  result   rsp_valid, rsp_item            one-cycle strobe, always taken
//  config   csr_we, csr_wdata              fit mode, written when csr_we
//
// Alloc: a scan of the opened pages, a page open when no block fits, then the splits;
// the single table read port paces the scan. Free: a check of the block, then a read,
// check and write per merge level. One item at a time; busy is high meanwhile.
// Synchronous reset clears fit mode and the page count; table pages are cleared
// as they are opened. The result is registered on the last step.
`timescale 1ns / 1ps
module buddy_block_allocator_core import bba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   bba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
